### hdl/lrw_pkg.sv
// shared types, constants and helper functions of the lattice random walk generator
package lrw_pkg;

    localparam int WORD_W     = 64;
    localparam int X_BITS     = 40;
    localparam int Y_BITS     = 16;
    localparam int OUT_X_W    = 40;
    localparam int OUT_Y_W    = 16;
    localparam int STEP_W     = 39;
    localparam int THR_W      = 54;
    localparam int WIDTH_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_W      = 160;
    localparam int SEED_WORDS = 4;
    localparam int SEED_IDX_W = $clog2(SEED_WORDS);
    localparam int QUEUE_DEPTH = 2;
    localparam int RHI_W      = WORD_W - 11;
    localparam int WEXT       = ((Y_BITS > WIDTH_W) ? Y_BITS : WIDTH_W) + 1;

    localparam logic [WEXT-1:0] Y_LIMIT = WEXT'(1) << Y_BITS;

    localparam logic CMD_START = 1'b0;

    localparam logic [CFG_IDX_W-1:0] REG_PLUS_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINUS_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLUS_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFLECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CAP     = 3'd5;

    localparam logic [THR_W-1:0]   RST_PLUS_X  = 54'd2251799813685248;
    localparam logic [THR_W-1:0]   RST_MINUS_X = 54'd4503599627370496;
    localparam logic [THR_W-1:0]   RST_PLUS_Y  = 54'd6755399441055744;
    localparam logic [WIDTH_W-1:0] RST_WIDTH   = 16'd5;
    localparam logic [STEP_W-1:0]  RST_CAP     = 39'd500000000;

    localparam logic [WORD_W-1:0] C_FMIX1    = 64'hff51afd7ed558ccd;
    localparam logic [WORD_W-1:0] C_FMIX2    = 64'hc4ceb9fe1a85ec53;
    localparam logic [WORD_W-1:0] C_GOLDEN   = 64'h9E3779B97F4A7C15;
    localparam logic [WORD_W-1:0] C_ROW      = 64'hC2B2AE3D27D4EB4F;
    localparam logic [WORD_W-1:0] C_RNG_SALT = 64'h5851F42D4C957F2D;
    localparam logic [WORD_W-1:0] C_DIS_SALT = 64'hA24BAED4963EE407;

    localparam int ROT_OUT   = 23;
    localparam int SHIFT_T   = 17;
    localparam int ROT_S3    = 45;
    localparam int SHIFT_MIX = 33;

    typedef struct packed {
        logic [X_BITS-1:0] x;
        logic [Y_BITS-1:0] y;
        logic [STEP_W-1:0] steps;
        logic              capped;
        logic [WORD_W-1:0] dseed;
    } entry_t;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] xs33(input logic [WORD_W-1:0] z);
        return z ^ (z >> SHIFT_MIX);
    endfunction

endpackage

### hdl/lrw_mul64.sv
// low half of a 64 by 64 product, partial products summed on one 32 by 32 multiplier
module lrw_mul64
    import lrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] p
);

    logic              busy_reg, busy_next;
    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] a_reg, b_reg, pp_reg, acc_reg;
    logic [31:0]       op_a, op_b;
    logic [WORD_W-1:0] prod, pp_next;

    always_comb
    begin
        op_a = a_reg[31:0];
        op_b = b_reg[31:0];
        case (phase_reg)
            2'd1:    op_a = a_reg[63:32];
            2'd2:    op_b = b_reg[63:32];
            default: ;
        endcase
        prod    = WORD_W'(op_a) * WORD_W'(op_b);
        pp_next = (phase_reg == 2'd0) ? prod : {prod[31:0], 32'b0};
    end

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        if (start && !busy_reg)
        begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
        end
        else if (busy_reg)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            pp_reg <= pp_next;
            if (phase_reg != 2'd0)
            begin
                acc_reg <= acc_reg + pp_reg;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier started while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == 2'd3) |=> (done_reg && !busy_reg))
        else $error("multiplier finished without done");

endmodule

### hdl/lrw_fmix.sv
// fmix64 finalizer sequenced over its own 64-bit multiplier
module lrw_fmix
    import lrw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] z_in,
    output logic              done,
    output logic [WORD_W-1:0] z_out
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_MUL1 = 2'd1;
    localparam logic [1:0] M_MUL2 = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] z_out_reg;
    logic              mul_start, mul_done;
    logic [WORD_W-1:0] mul_a, mul_b, mul_p;

    lrw_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_comb
    begin
        mul_start  = 1'b0;
        mul_a      = xs33(z_in);
        mul_b      = C_FMIX1;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mul_start  = 1'b1;
                    state_next = M_MUL1;
                end
            end
            M_MUL1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xs33(mul_p);
                    mul_b      = C_FMIX2;
                    state_next = M_MUL2;
                end
            end
            M_MUL2:
            begin
                if (mul_done)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == M_MUL2 && mul_done)
        begin
            z_out_reg <= xs33(mul_p);
        end
    end

    assign done  = done_reg;
    assign z_out = z_out_reg;

endmodule

### hdl/lrw_front.sv
// front end: word intake, config registers, generator, seeding and walker update
module lrw_front
    import lrw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  q_push,
    output entry_t                q_entry,
    input  logic                  q_full
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MOVE  = 3'd1;
    localparam logic [2:0] F_SEEDK = 3'd2;
    localparam logic [2:0] F_SEEDW = 3'd3;
    localparam logic [2:0] F_SEEDD = 3'd4;
    localparam logic [2:0] F_PUSH  = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [WORD_W-1:0]     s_reg [SEED_WORDS];
    logic [WORD_W-1:0]     s_next [SEED_WORDS];
    logic [WORD_W-1:0]     disorder_reg, disorder_next;
    logic [X_BITS-1:0]     x_reg, x_next;
    logic [Y_BITS-1:0]     y_reg, y_next;
    logic [STEP_W-1:0]     steps_reg, steps_next;
    logic                  cap_reg, cap_next;
    logic [RHI_W-1:0]      rhi_reg, rhi_next;
    logic [WORD_W-1:0]     seed_reg, seed_next;
    logic [WORD_W-1:0]     k_reg, k_next;
    logic [SEED_IDX_W-1:0] idx_reg, idx_next;

    logic [THR_W-1:0]      plus_x_reg, plus_x_next;
    logic [THR_W-1:0]      minus_x_reg, minus_x_next;
    logic [THR_W-1:0]      plus_y_reg, plus_y_next;
    logic [WIDTH_W-1:0]    width_reg, width_next;
    logic                  reflect_reg, reflect_next;
    logic [STEP_W-1:0]     step_cap_reg, step_cap_next;

    logic                  fx_start, fx_done;
    logic [WORD_W-1:0]     fx_in, fx_out;

    logic [WORD_W-1:0]     rnd, t_sh, s2a, s3a, s1b, s0b;
    logic [THR_W-1:0]      k_draw;
    logic [WEXT-1:0]       w_raw, w_eff, y_ext, y_inc;

    lrw_fmix u_fmix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fx_start),
        .z_in  (fx_in),
        .done  (fx_done),
        .z_out (fx_out)
    );

    assign s_axis_tready = (state_reg == F_IDLE);
    assign cfg_ready     = 1'b1;

    // xoshiro256++ output and state advance
    always_comb
    begin
        rnd  = rotl64(s_reg[0] + s_reg[3], ROT_OUT) + s_reg[0];
        t_sh = s_reg[1] << SHIFT_T;
        s2a  = s_reg[2] ^ s_reg[0];
        s3a  = s_reg[3] ^ s_reg[1];
        s1b  = s_reg[1] ^ s2a;
        s0b  = s_reg[0] ^ s3a;
    end

    always_comb
    begin
        k_draw = {1'b0, rhi_reg} + THR_W'(1);
        w_raw  = WEXT'(width_reg);
        if (width_reg == '0)
        begin
            w_eff = WEXT'(1);
        end
        else if (w_raw > Y_LIMIT)
        begin
            w_eff = Y_LIMIT;
        end
        else
        begin
            w_eff = w_raw;
        end
        y_ext = WEXT'(y_reg);
        y_inc = y_ext + WEXT'(1);
    end

    always_comb
    begin
        state_next    = state_reg;
        for (int i = 0; i < SEED_WORDS; i++)
        begin
            s_next[i] = s_reg[i];
        end
        disorder_next = disorder_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        steps_next    = steps_reg;
        cap_next      = cap_reg;
        rhi_next      = rhi_reg;
        seed_next     = seed_reg;
        k_next        = k_reg;
        idx_next      = idx_reg;
        fx_start      = 1'b0;
        fx_in         = s_axis_tdata ^ C_RNG_SALT;
        q_push        = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_START)
                    begin
                        seed_next  = s_axis_tdata;
                        fx_start   = 1'b1;
                        state_next = F_SEEDK;
                    end
                    else if (steps_reg >= step_cap_reg)
                    begin
                        cap_next   = 1'b1;
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        s_next[0]  = s0b;
                        s_next[1]  = s1b;
                        s_next[2]  = s2a ^ t_sh;
                        s_next[3]  = rotl64(s3a, ROT_S3);
                        rhi_next   = rnd[WORD_W-1:11];
                        state_next = F_MOVE;
                    end
                end
            end
            F_MOVE:
            begin
                if (k_draw < plus_x_reg)
                begin
                    x_next = x_reg + X_BITS'(1);
                end
                else if (k_draw < minus_x_reg)
                begin
                    x_next = x_reg - X_BITS'(1);
                end
                else if (k_draw < plus_y_reg)
                begin
                    if (!reflect_reg)
                    begin
                        y_next = (y_inc >= w_eff) ? '0 : y_inc[Y_BITS-1:0];
                    end
                    else if (y_inc < w_eff)
                    begin
                        y_next = y_inc[Y_BITS-1:0];
                    end
                end
                else
                begin
                    if (!reflect_reg)
                    begin
                        y_next = (y_reg == '0) ? Y_BITS'(w_eff - WEXT'(1))
                                               : y_reg - Y_BITS'(1);
                    end
                    else if (y_reg != '0)
                    begin
                        y_next = y_reg - Y_BITS'(1);
                    end
                end
                steps_next = steps_reg + STEP_W'(1);
                cap_next   = 1'b0;
                state_next = F_PUSH;
            end
            F_SEEDK:
            begin
                if (fx_done)
                begin
                    k_next     = fx_out + C_GOLDEN;
                    fx_start   = 1'b1;
                    fx_in      = fx_out + C_GOLDEN;
                    idx_next   = '0;
                    state_next = F_SEEDW;
                end
            end
            F_SEEDW:
            begin
                if (fx_done)
                begin
                    s_next[idx_reg] = fx_out;
                    fx_start        = 1'b1;
                    if (idx_reg == SEED_IDX_W'(SEED_WORDS - 1))
                    begin
                        fx_in      = seed_reg ^ C_DIS_SALT;
                        state_next = F_SEEDD;
                    end
                    else
                    begin
                        k_next   = k_reg + C_GOLDEN;
                        fx_in    = k_reg + C_GOLDEN;
                        idx_next = idx_reg + SEED_IDX_W'(1);
                    end
                end
            end
            F_SEEDD:
            begin
                if (fx_done)
                begin
                    disorder_next = fx_out;
                    // all-zero generator is not a valid xoshiro state
                    if ((s_reg[0] | s_reg[1] | s_reg[2] | s_reg[3]) == '0)
                    begin
                        s_next[0] = WORD_W'(1);
                    end
                    x_next     = '0;
                    y_next     = '0;
                    steps_next = '0;
                    cap_next   = 1'b0;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        plus_x_next   = plus_x_reg;
        minus_x_next  = minus_x_reg;
        plus_y_next   = plus_y_reg;
        width_next    = width_reg;
        reflect_next  = reflect_reg;
        step_cap_next = step_cap_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PLUS_X:  plus_x_next   = cfg_data[THR_W-1:0];
                REG_MINUS_X: minus_x_next  = cfg_data[THR_W-1:0];
                REG_PLUS_Y:  plus_y_next   = cfg_data[THR_W-1:0];
                REG_WIDTH:   width_next    = cfg_data[WIDTH_W-1:0];
                REG_REFLECT: reflect_next  = cfg_data[0];
                REG_CAP:     step_cap_next = cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            for (int i = 0; i < SEED_WORDS; i++)
            begin
                s_reg[i] <= '0;
            end
            disorder_reg <= '0;
            x_reg        <= '0;
            y_reg        <= '0;
            steps_reg    <= '0;
            cap_reg      <= 1'b0;
            idx_reg      <= '0;
            plus_x_reg   <= RST_PLUS_X;
            minus_x_reg  <= RST_MINUS_X;
            plus_y_reg   <= RST_PLUS_Y;
            width_reg    <= RST_WIDTH;
            reflect_reg  <= 1'b0;
            step_cap_reg <= RST_CAP;
        end
        else
        begin
            state_reg    <= state_next;
            for (int i = 0; i < SEED_WORDS; i++)
            begin
                s_reg[i] <= s_next[i];
            end
            disorder_reg <= disorder_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            steps_reg    <= steps_next;
            cap_reg      <= cap_next;
            idx_reg      <= idx_next;
            plus_x_reg   <= plus_x_next;
            minus_x_reg  <= minus_x_next;
            plus_y_reg   <= plus_y_next;
            width_reg    <= width_next;
            reflect_reg  <= reflect_next;
            step_cap_reg <= step_cap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rhi_reg  <= rhi_next;
        seed_reg <= seed_next;
        k_reg    <= k_next;
    end

    always_comb
    begin
        q_entry.x      = x_reg;
        q_entry.y      = y_reg;
        q_entry.steps  = steps_reg;
        q_entry.capped = cap_reg;
        q_entry.dseed  = disorder_reg;
    end

endmodule

### hdl/lrw_queue.sv
// short fifo of walker snapshots between front and back
module lrw_queue
    import lrw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t entry_in,
    output logic   full,
    output logic   valid,
    input  logic   pop,
    output entry_t entry_out
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid     = (count_reg != '0);
    assign entry_out = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### hdl/lrw_back.sv
// back end: site hash of each snapshot and the output register
module lrw_back
    import lrw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  entry_t           q_entry,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MX   = 3'd1;
    localparam logic [2:0] B_MY   = 3'd2;
    localparam logic [2:0] B_FX   = 3'd3;
    localparam logic [2:0] B_OUT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    entry_t            e_reg;
    logic [WORD_W-1:0] site_reg, hash_reg;
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg;
    logic              load_out, slot_free;

    logic              mul_start, mul_done;
    logic [WORD_W-1:0] mul_a, mul_b, mul_p;
    logic              fx_start, fx_done;
    logic [WORD_W-1:0] fx_in, fx_out;

    lrw_mul64 u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    lrw_fmix u_fmix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fx_start),
        .z_in  (fx_in),
        .done  (fx_done),
        .z_out (fx_out)
    );

    assign slot_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        mul_start  = 1'b0;
        mul_a      = WORD_W'($signed(q_entry.x));
        mul_b      = C_GOLDEN;
        fx_start   = 1'b0;
        fx_in      = site_reg + mul_p;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    mul_start  = 1'b1;
                    state_next = B_MX;
                end
            end
            B_MX:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = WORD_W'(e_reg.y);
                    mul_b      = C_ROW;
                    state_next = B_MY;
                end
            end
            B_MY:
            begin
                if (mul_done)
                begin
                    fx_start   = 1'b1;
                    state_next = B_FX;
                end
            end
            B_FX:
            begin
                if (fx_done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            e_reg <= q_entry;
        end
        if (state_reg == B_MX && mul_done)
        begin
            site_reg <= mul_p + e_reg.dseed;
        end
        if (state_reg == B_FX && fx_done)
        begin
            hash_reg <= fx_out;
        end
        if (load_out)
        begin
            m_data_reg <= {e_reg.capped, hash_reg, e_reg.steps,
                           OUT_Y_W'(e_reg.y), OUT_X_W'($signed(e_reg.x))};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

### hdl/lattice_random_walk_generator.sv
// top level of the lattice random walk generator
// front: a step word advances the generator and moves the walker, at the step cap it only
// flags the snapshot capped, and a start word runs six fmix64 to seed generator and disorder
// back end: site hash of each snapshot on its 32x32 multiplier and fmix64, sets the step word rate
// a 2-entry queue lets the front take the next word while the back end hashes
// rst_n async low: thresholds and cap to defaults, generator and walker cleared
module lattice_random_walk_generator
    import lrw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [WORD_W-1:0]     s_axis_tdata,   // trajectory_seed
    input  logic                  s_axis_tuser,   // command
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // position_x, position_y, step_count, site_hash, capped
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic   q_push, q_full, q_valid, q_pop;
    entry_t q_in, q_out;

    lrw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_push        (q_push),
        .q_entry       (q_in),
        .q_full        (q_full)
    );

    lrw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .entry_in  (q_in),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .entry_out (q_out)
    );

    lrw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_entry       (q_out),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### dv/tb_top.sv
// self-checking stream testbench for the lattice random walk generator
`timescale 1ns / 100ps

module tb_top;
    import lrw_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 120;
    localparam int RANDOM_ITEMS  = 1325;

    localparam logic              CMD_STEP = ~CMD_START;
    localparam logic [WORD_W-1:0] ONE_53   = 64'd1 << 53;
    localparam logic [THR_W-1:0]  THR_MAX  = '1;
    localparam logic [STEP_W-1:0] CAP_MAX  = '1;

    typedef struct packed {
        logic              capped;
        logic [WORD_W-1:0] site_hash;
        logic [STEP_W-1:0] steps;
        logic [Y_BITS-1:0] y;
        logic [X_BITS-1:0] x;
    } walk_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    // walker model: configuration
    logic [THR_W-1:0]   thr_px     = RST_PLUS_X;
    logic [THR_W-1:0]   thr_mx     = RST_MINUS_X;
    logic [THR_W-1:0]   thr_py     = RST_PLUS_Y;
    logic [WIDTH_W-1:0] rows       = RST_WIDTH;
    logic               reflect_on = 1'b0;
    logic [STEP_W-1:0]  cap_limit  = RST_CAP;

    // walker model: state
    logic [WORD_W-1:0] rng_s [SEED_WORDS] = '{default: '0};
    logic [WORD_W-1:0] site_key   = '0;
    logic [X_BITS-1:0] col_x      = '0;
    logic [Y_BITS-1:0] row_y      = '0;
    logic [STEP_W-1:0] step_total = '0;
    logic              frozen     = 1'b0;

    walk_result_t pending_results[$];
    int           fail_count = 0;
    bit           no_idle    = 1'b0;

    lattice_random_walk_generator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [WORD_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [WORD_W-1:0] avalanche64(input logic [WORD_W-1:0] z);
        z = z ^ (z >> 33);
        z = z * C_FMIX1;
        z = z ^ (z >> 33);
        z = z * C_FMIX2;
        return z ^ (z >> 33);
    endfunction

    function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] v, input int n);
        logic [2*WORD_W-1:0] both;
        both = {v, v} << n;
        return both[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] xoshiro_next();
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] t;
        r = rol64(rng_s[0] + rng_s[3], 23) + rng_s[0];
        t = rng_s[1] << 17;
        rng_s[2] = rng_s[2] ^ rng_s[0];
        rng_s[3] = rng_s[3] ^ rng_s[1];
        rng_s[1] = rng_s[1] ^ rng_s[2];
        rng_s[0] = rng_s[0] ^ rng_s[3];
        rng_s[2] = rng_s[2] ^ t;
        rng_s[3] = rol64(rng_s[3], 45);
        return r;
    endfunction

    function automatic walk_result_t advance_walker(input logic cmd,
                                                    input logic [WORD_W-1:0] seed);
        walk_result_t      res;
        logic [WORD_W-1:0] k;
        logic [WORD_W-1:0] xs;
        logic [WORD_W-1:0] site;
        logic [WEXT-1:0]   w;
        logic [WEXT-1:0]   ynext;
        if (cmd == CMD_START)
        begin
            k = avalanche64(seed ^ C_RNG_SALT);
            for (int i = 0; i < SEED_WORDS; i++)
            begin
                k = k + C_GOLDEN;
                rng_s[i] = avalanche64(k);
            end
            if ((rng_s[0] | rng_s[1] | rng_s[2] | rng_s[3]) == '0)
                rng_s[0] = 64'd1;
            site_key   = avalanche64(seed ^ C_DIS_SALT);
            col_x      = '0;
            row_y      = '0;
            step_total = '0;
            frozen     = 1'b0;
        end
        else if (step_total >= cap_limit)
        begin
            frozen = 1'b1;
        end
        else
        begin
            k = (xoshiro_next() >> 11) + 64'd1;
            w = WEXT'(rows);
            if (w == '0)
                w = WEXT'(1);
            if (w > Y_LIMIT)
                w = Y_LIMIT;
            ynext  = WEXT'(row_y) + WEXT'(1);
            frozen = 1'b0;
            if (k < WORD_W'(thr_px))
                col_x = col_x + X_BITS'(1);
            else if (k < WORD_W'(thr_mx))
                col_x = col_x - X_BITS'(1);
            else if (k < WORD_W'(thr_py))
            begin
                if (!reflect_on)
                    row_y = (ynext >= w) ? '0 : ynext[Y_BITS-1:0];
                else if (ynext < w)
                    row_y = ynext[Y_BITS-1:0];
            end
            else
            begin
                if (!reflect_on)
                    row_y = (row_y == '0) ? Y_BITS'(w - WEXT'(1)) : row_y - Y_BITS'(1);
                else if (row_y != '0)
                    row_y = row_y - Y_BITS'(1);
            end
            step_total = step_total + STEP_W'(1);
        end
        xs   = {{(WORD_W - X_BITS){col_x[X_BITS-1]}}, col_x};
        site = xs * C_GOLDEN + WORD_W'(row_y) * C_ROW;
        res.x         = col_x;
        res.y         = row_y;
        res.steps     = step_total;
        res.site_hash = avalanche64(site + site_key);
        res.capped    = frozen;
        return res;
    endfunction

    task automatic push_command(input logic cmd, input logic [WORD_W-1:0] seed);
        int           gap;
        walk_result_t predicted;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= seed;
        @(posedge clk);
        while (s_axis_tready !== 1'b1) @(posedge clk);
        predicted = advance_walker(cmd, seed);
        pending_results.insert(pending_results.size(), predicted);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PLUS_X:  thr_px     = val[THR_W-1:0];
            REG_MINUS_X: thr_mx     = val[THR_W-1:0];
            REG_PLUS_Y:  thr_py     = val[THR_W-1:0];
            REG_WIDTH:   rows       = val[WIDTH_W-1:0];
            REG_REFLECT: reflect_on = val[0];
            REG_CAP:     cap_limit  = val[STEP_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic set_moves(input logic [THR_W-1:0] px, input logic [THR_W-1:0] mx,
                             input logic [THR_W-1:0] py);
        write_reg(REG_PLUS_X, CFG_DATA_W'(px));
        write_reg(REG_MINUS_X, CFG_DATA_W'(mx));
        write_reg(REG_PLUS_Y, CFG_DATA_W'(py));
    endtask

    task automatic drain_walker();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [THR_W-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return THR_W'(1);
            2:       return THR_W'(ONE_53);
            3:       return THR_W'(ONE_53 + 1);
            default: return THR_MAX;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // output side: random stalls, every accepted word compared with the oldest prediction
    initial
    begin : result_checker
        walk_result_t got;
        walk_result_t want;
        int           gap;
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (m_axis_tvalid !== 1'b1) @(posedge clk);
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $error("result word with no prediction pending: 0x%0h", got);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("position_x", WORD_W'(want.x), WORD_W'(got.x));
                check_field("position_y", WORD_W'(want.y), WORD_W'(got.y));
                check_field("step_count", WORD_W'(want.steps), WORD_W'(got.steps));
                check_field("site_hash", want.site_hash, got.site_hash);
                check_field("capped", WORD_W'(want.capped), WORD_W'(got.capped));
            end
        end
    end

    // steps after reset run on the all-zero generator with a zero disorder seed
    task automatic test_unseeded_steps();
        push_command(CMD_STEP, rand64());
        push_command(CMD_STEP, '1);
    endtask

    task automatic test_seed_extremes();
        push_command(CMD_START, '0);
        push_command(CMD_STEP, '0);
        push_command(CMD_START, '1);
        push_command(CMD_STEP, rand64());
        push_command(CMD_START, 64'h8000_0000_0000_0000);
        push_command(CMD_STEP, rand64());
    endtask

    task automatic test_move_kinds();
        // threshold above 2^53 forces +y, periodic wrap on a 3-row strip
        drain_walker();
        set_moves('0, '0, THR_MAX);
        write_reg(REG_WIDTH, 64'd3);
        write_reg(REG_REFLECT, 64'd0);
        push_command(CMD_START, rand64());
        repeat (5) push_command(CMD_STEP, rand64());
        // reflecting wall refuses +y, then zero width acts as one row
        drain_walker();
        write_reg(REG_REFLECT, 64'd1);
        push_command(CMD_STEP, rand64());
        drain_walker();
        write_reg(REG_WIDTH, 64'd0);
        push_command(CMD_STEP, rand64());
        // row beyond a lowered width
        drain_walker();
        write_reg(REG_REFLECT, 64'd0);
        write_reg(REG_WIDTH, 64'd2);
        push_command(CMD_STEP, rand64());
        drain_walker();
        set_moves('0, '0, '0);
        push_command(CMD_STEP, rand64());
        push_command(CMD_STEP, rand64());
        drain_walker();
        write_reg(REG_REFLECT, 64'd1);
        push_command(CMD_STEP, rand64());
        // -x at the 2^53 bound, then +x at the top
        drain_walker();
        set_moves('0, THR_W'(ONE_53), THR_W'(ONE_53));
        push_command(CMD_STEP, rand64());
        drain_walker();
        set_moves(THR_MAX, '0, '0);
        push_command(CMD_STEP, rand64());
    endtask

    task automatic test_step_cap();
        drain_walker();
        set_moves(RST_PLUS_X, RST_MINUS_X, RST_PLUS_Y);
        write_reg(REG_CAP, 64'd0);
        write_reg(REG_WIDTH, 64'd65535);
        push_command(CMD_STEP, rand64());
        push_command(CMD_STEP, rand64());
        drain_walker();
        write_reg(REG_CAP, CFG_DATA_W'(CAP_MAX));
        push_command(CMD_START, rand64());
        push_command(CMD_STEP, rand64());
        drain_walker();
        write_reg(REG_CAP, 64'd1);
        push_command(CMD_STEP, rand64());
    endtask

    task automatic test_random_walks();
        int                sent;
        int                phase_len;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] t;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_walker();
            case ($urandom_range(0, 2))
                0:
                begin
                    a = rand64() % (ONE_53 + 1);
                    b = rand64() % (ONE_53 + 1);
                    c = rand64() % (ONE_53 + 1);
                    if (a > b) begin t = a; a = b; b = t; end
                    if (b > c) begin t = b; b = c; c = t; end
                    if (a > b) begin t = a; a = b; b = t; end
                    set_moves(THR_W'(a), THR_W'(b), THR_W'(c));
                end
                1:       set_moves(THR_W'(rand64()), THR_W'(rand64()), THR_W'(rand64()));
                default: set_moves(pick_edge(), pick_edge(), pick_edge());
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(REG_WIDTH, 64'd0);
                1:       write_reg(REG_WIDTH, 64'd65535);
                2:       write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(1, 65535)));
                default: write_reg(REG_WIDTH, CFG_DATA_W'($urandom_range(1, 8)));
            endcase
            write_reg(REG_REFLECT, CFG_DATA_W'($urandom_range(0, 1)));
            case ($urandom_range(0, 2))
                0:       write_reg(REG_CAP, CFG_DATA_W'($urandom_range(0, 120)));
                1:       write_reg(REG_CAP, CFG_DATA_W'(CAP_MAX));
                default: write_reg(REG_CAP, CFG_DATA_W'(STEP_W'(rand64())));
            endcase
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 90);
            if ($urandom_range(0, 9) < 7)
            begin
                push_command(CMD_START, rand64());
                sent++;
            end
            for (int i = 0; i < phase_len; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    push_command(CMD_START, rand64());
                else
                    push_command(CMD_STEP, rand64());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : test_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_unseeded_steps();
        test_seed_extremes();
        test_move_kinds();
        test_step_cap();
        test_random_walks();
        drain_walker();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### lattice_random_walk_generator.f
hdl/lrw_pkg.sv
hdl/lrw_mul64.sv
hdl/lrw_fmix.sv
hdl/lrw_front.sv
hdl/lrw_queue.sv
hdl/lrw_back.sv
hdl/lattice_random_walk_generator.sv
dv/tb_top.sv
